// ===== rtl/satsp_pkg.sv =====
package satsp_pkg;

  // default geometry
  localparam int SETS_DEF = 64;
  localparam int WAYS_DEF = 8;

  // field widths
  localparam int ADDR_W = 32;
  localparam int OP_W   = 3;
  localparam int STAT_W = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_ACCESS  = 3'd0;
  localparam logic [OP_W-1:0] OP_CONTAIN = 3'd1;
  localparam logic [OP_W-1:0] OP_FILL    = 3'd2;
  localparam logic [OP_W-1:0] OP_PIN     = 3'd3;
  localparam logic [OP_W-1:0] OP_UNPIN   = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_PRESENT = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_VICTIM   = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic clr;     // clear one metadata row
    logic load;    // capture incoming item
    logic rd_in;   // read set taken straight from the incoming address
    logic rd_set;  // read set held in the set index register
    logic commit;  // write back the set and load the result
  } satsp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic idx_done;
    logic out_free;
  } satsp_sts_t;

endpackage

// ===== rtl/set_assoc_tag_store_with_pinning.sv =====
// Sequence: with a power-of-two set count the set is read as the item is accepted; otherwise
// the set remainder is reduced first and the set read after it. Each item reads its set,
// then writes it back and registers the result, which waits while a held result is stalled;
// one item is handled at a time, and the next is taken while a finished result still waits.
// Reset: synchronous, active low; afterwards a clearing pass over all SETS rows zeroes the
// valid, pin and counter bits one set a cycle, during which no item is accepted.
module set_assoc_tag_store_with_pinning #(
  parameter int SETS = satsp_pkg::SETS_DEF,
  parameter int WAYS = satsp_pkg::WAYS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [satsp_pkg::OP_W-1:0]    in_op,
  input  logic [satsp_pkg::ADDR_W-1:0]  in_block_addr,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic [satsp_pkg::STAT_W-1:0]  out_status,
  output logic                          out_evicted,
  output logic [satsp_pkg::ADDR_W-1:0]  out_victim_addr
);

  satsp_pkg::satsp_cmd_t cmd;
  satsp_pkg::satsp_sts_t sts;

  // sequencing
  satsp_ctrl #(.SETS(SETS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // tag and metadata storage with lookup logic
  satsp_dp #(.SETS(SETS), .WAYS(WAYS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_op           (in_op),
    .in_block_addr   (in_block_addr),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_status      (out_status),
    .out_evicted     (out_evicted),
    .out_victim_addr (out_victim_addr),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

// ===== rtl/satsp_ram.sv =====
module satsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/satsp_ctrl.sv =====
module satsp_ctrl #(
  parameter int SETS = satsp_pkg::SETS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  satsp_pkg::satsp_sts_t sts,
  output satsp_pkg::satsp_cmd_t cmd
);

  localparam bit POW2 = (SETS & (SETS - 1)) == 0;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_MOD   = 2'd2;
  localparam logic [1:0] S_LOOK  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (POW2) begin
            cmd.rd_in = 1'b1;
            state_nxt = S_LOOK;
          end else begin
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (sts.idx_done) begin
          cmd.rd_set = 1'b1;
          state_nxt  = S_LOOK;
        end
      end
      S_LOOK: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/satsp_dp.sv =====
module satsp_dp #(
  parameter int SETS = satsp_pkg::SETS_DEF,
  parameter int WAYS = satsp_pkg::WAYS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [satsp_pkg::OP_W-1:0]    in_op,
  input  logic [satsp_pkg::ADDR_W-1:0]  in_block_addr,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic [satsp_pkg::STAT_W-1:0]  out_status,
  output logic                          out_evicted,
  output logic [satsp_pkg::ADDR_W-1:0]  out_victim_addr,
  input  satsp_pkg::satsp_cmd_t         cmd,
  output satsp_pkg::satsp_sts_t         sts
);

  localparam int  AW   = satsp_pkg::ADDR_W;
  localparam int  SW   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int  CW   = $clog2(WAYS + 1);
  localparam int  MW   = 2 + CW;
  localparam bit  POW2 = (SETS & (SETS - 1)) == 0;
  localparam int  NIBS = AW / 4;
  localparam int  FW   = SW + 7;

  logic [satsp_pkg::OP_W-1:0] op_r;
  logic [AW-1:0]              addr_r;
  logic [SW-1:0]              set_idx;
  logic [SW-1:0]              in_set;
  logic                       idx_done;
  logic [SW-1:0]              clr_cnt_r;

  logic [WAYS*MW-1:0]         meta_rd;
  logic [WAYS*MW-1:0]         meta_new;
  logic [WAYS*MW-1:0]         meta_wdata;
  logic [SW-1:0]              meta_waddr;
  logic                       meta_we;
  logic [WAYS*AW-1:0]         tag_rd;
  logic [WAYS*AW-1:0]         tag_new;
  logic                       tag_we;
  logic                       rd_en;
  logic [SW-1:0]              rd_addr;

  logic                       hit_nxt;
  logic [satsp_pkg::STAT_W-1:0] status_nxt;
  logic                       evicted_nxt;
  logic [AW-1:0]              victim_nxt;

  logic                       out_valid_r;
  logic                       hit_r;
  logic [satsp_pkg::STAT_W-1:0] status_r;
  logic                       evicted_r;
  logic [AW-1:0]              victim_r;

  function automatic logic [CW-1:0] adv_cnt(input logic [CW-1:0] c);
    if (c >= CW'(WAYS - 1)) begin
      return '0;
    end
    return c + 1'b1;
  endfunction

  // weight of address nibble i in the set remainder, 16**i mod SETS
  function automatic int nib_weight(input int i);
    int w;
    w = 1;
    for (int k = 0; k < i; k++) begin
      w = w * 16;
      while (w >= SETS) begin
        w = w - SETS;
      end
    end
    return w;
  endfunction

  // subtract SETS shifted by k when it fits
  function automatic logic [FW-1:0] red_step(input logic [FW-1:0] x, input int k);
    logic [FW-1:0] m;
    m = FW'(SETS) << k;
    if (x >= m) begin
      return x - m;
    end
    return x;
  endfunction

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      addr_r <= in_block_addr;
    end
  end

  assign in_set = in_block_addr[SW-1:0] & SW'(SETS - 1);

  // set index: a mask for power-of-two set counts, else a folded remainder
  generate
    if (POW2) begin : g_mask
      logic [SW-1:0] set_q_r;
      always_ff @(posedge clk) begin
        if (cmd.load) begin
          set_q_r <= in_set;
        end
      end
      assign set_idx  = set_q_r;
      assign idx_done = 1'b1;
    end else begin : g_rem
      logic [FW-1:0] fold;
      logic [FW-1:0] fold_r;
      logic [1:0]    phase_r;
      logic          busy_r;
      logic          done_r;

      // nibbles weighted by their remainders, below 120 times SETS
      always_comb begin
        fold = '0;
        for (int i = 0; i < NIBS; i++) begin
          fold = fold + FW'(in_block_addr[4*i +: 4]) * FW'(nib_weight(i));
        end
      end

      // reduce below SETS by subtracting 64, 32, 16, then 8, 4, then 2, 1 times SETS in turn
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
          done_r <= 1'b0;
        end else if (cmd.load) begin
          busy_r  <= 1'b1;
          done_r  <= 1'b0;
          phase_r <= '0;
          fold_r  <= fold;
        end else if (busy_r) begin
          phase_r <= phase_r + 1'b1;
          case (phase_r)
            2'd0: begin
              fold_r <= red_step(red_step(red_step(fold_r, 6), 5), 4);
            end
            2'd1: begin
              fold_r <= red_step(red_step(fold_r, 3), 2);
            end
            default: begin
              fold_r <= red_step(red_step(fold_r, 1), 0);
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          endcase
        end
      end
      assign set_idx  = fold_r[SW-1:0];
      assign idx_done = done_r;
    end
  endgenerate

  // clearing sweep over metadata rows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // memory ports
  assign rd_en      = cmd.rd_in | cmd.rd_set;
  assign rd_addr    = cmd.rd_in ? in_set : set_idx;
  assign meta_we    = cmd.clr | cmd.commit;
  assign meta_waddr = cmd.clr ? clr_cnt_r : set_idx;
  assign meta_wdata = cmd.clr ? '0 : meta_new;

  satsp_ram #(.WIDTH(WAYS*MW), .DEPTH(SETS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (meta_rd)
  );

  satsp_ram #(.WIDTH(WAYS*AW), .DEPTH(SETS)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (set_idx),
    .wdata (tag_new),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (tag_rd)
  );

  // lookup, victim choice and set update
  always_comb begin
    logic [WAYS-1:0] v;
    logic [WAYS-1:0] p;
    logic [CW-1:0]   c [WAYS];
    logic [AW-1:0]   t [WAYS];
    logic [WAYS-1:0] match;
    logic [WAYS-1:0] match_1h;
    logic [WAYS-1:0] inval_1h;
    logic [WAYS-1:0] low_1h;
    logic [WAYS-1:0] vic_1h;
    logic            match_any;
    logic            inval_any;
    logic            vic_any;
    logic [AW-1:0]   vic_tag;
    logic            nv;
    logic            np;
    logic [CW-1:0]   nc;

    for (int j = 0; j < WAYS; j++) begin
      v[j]     = meta_rd[j*MW + MW - 1];
      p[j]     = meta_rd[j*MW + MW - 2];
      c[j]     = meta_rd[j*MW +: CW];
      t[j]     = tag_rd[j*AW +: AW];
      match[j] = v[j] && (t[j] == addr_r);
    end

    match_1h  = match & (~match + 1'b1);
    match_any = |match;
    inval_1h  = ~v & (v + 1'b1);
    inval_any = ~&v;

    // lowest counter below the way count, lowest way on ties
    for (int j = 0; j < WAYS; j++) begin
      low_1h[j] = c[j] < CW'(WAYS);
      for (int k = 0; k < WAYS; k++) begin
        if (k < j) begin
          low_1h[j] = low_1h[j] && (c[j] < c[k]);
        end else if (k > j) begin
          low_1h[j] = low_1h[j] && (c[j] <= c[k]);
        end
      end
    end

    if (inval_any) begin
      vic_1h = inval_1h;
    end else if (WAYS == 1) begin
      vic_1h = ~p;
    end else begin
      vic_1h = low_1h;
    end
    vic_any = |vic_1h;

    vic_tag = '0;
    for (int j = 0; j < WAYS; j++) begin
      vic_tag = vic_tag | (t[j] & {AW{vic_1h[j]}});
    end

    // per-way update
    meta_new = meta_rd;
    tag_new  = tag_rd;
    for (int j = 0; j < WAYS; j++) begin
      nv = v[j];
      np = p[j];
      nc = c[j];
      case (op_r)
        satsp_pkg::OP_ACCESS: begin
          if (match_1h[j] && !p[j] && (WAYS != 1)) begin
            nc = adv_cnt(c[j]);
          end
        end
        satsp_pkg::OP_FILL: begin
          if (vic_1h[j]) begin
            nv = 1'b1;
            np = 1'b0;
            nc = CW'(1);
            tag_new[j*AW +: AW] = addr_r;
          end
        end
        satsp_pkg::OP_PIN: begin
          if (match_1h[j]) begin
            np = 1'b1;
            nc = CW'(WAYS);
          end
        end
        satsp_pkg::OP_UNPIN: begin
          if (match_1h[j]) begin
            np = 1'b0;
            nc = adv_cnt(c[j]);
          end
        end
        default: begin
          nc = c[j];
        end
      endcase
      meta_new[j*MW +: MW] = {nv, np, nc};
    end

    // result fields
    hit_nxt     = 1'b0;
    status_nxt  = satsp_pkg::ST_OK;
    evicted_nxt = 1'b0;
    victim_nxt  = '0;
    tag_we      = 1'b0;
    case (op_r)
      satsp_pkg::OP_ACCESS, satsp_pkg::OP_CONTAIN: begin
        hit_nxt = match_any;
      end
      satsp_pkg::OP_FILL: begin
        if (!vic_any) begin
          status_nxt = satsp_pkg::ST_NO_VICTIM;
        end else begin
          tag_we = cmd.commit;
          if (!inval_any) begin
            evicted_nxt = 1'b1;
            victim_nxt  = vic_tag;
          end
        end
      end
      satsp_pkg::OP_PIN, satsp_pkg::OP_UNPIN: begin
        if (!match_any) begin
          status_nxt = satsp_pkg::ST_NOT_PRESENT;
        end
      end
      default: begin
        hit_nxt = 1'b0;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit_r     <= hit_nxt;
      status_r  <= status_nxt;
      evicted_r <= evicted_nxt;
      victim_r  <= victim_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = hit_r;
  assign out_status      = status_r;
  assign out_evicted     = evicted_r;
  assign out_victim_addr = victim_r;

  assign sts.clr_last = (clr_cnt_r == SW'(SETS - 1));
  assign sts.idx_done = idx_done;
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule

// ===== rtl/satsp_chk.sv =====
module satsp_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [satsp_pkg::OP_W-1:0]    in_op,
  input logic [satsp_pkg::ADDR_W-1:0]  in_block_addr,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_hit,
  input logic [satsp_pkg::STAT_W-1:0]  out_status,
  input logic                          out_evicted,
  input logic [satsp_pkg::ADDR_W-1:0]  out_victim_addr
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit) && $stable(out_status)
      && $stable(out_evicted) && $stable(out_victim_addr))
    else $error("stalled result changed");

  // one item at a time: an accepted item closes the input
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after an accepted item");

  // a hit never comes with an error or an eviction
  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> (out_status == satsp_pkg::ST_OK) && !out_evicted)
    else $error("hit reported with error or eviction");

  // victim address only shown on an eviction
  a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted |-> out_victim_addr == '0)
    else $error("victim address without eviction");

  // an eviction means a successful fill
  a_evict_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> out_status == satsp_pkg::ST_OK)
    else $error("eviction with error status");

endmodule

bind set_assoc_tag_store_with_pinning satsp_chk u_satsp_chk (.*);
